FILE: rtl/cfvd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfvd_pkg
// Shared types, register map and CRC helpers of the command frame validator.
// ----------------------------------------------------------------------------
package cfvd_pkg;

  localparam int unsigned IdW      = 29;
  localparam int unsigned LenW     = 4;
  localparam int unsigned AddrW    = 5;
  localparam int unsigned CrcBytes = 7;
  localparam int unsigned CrcMsgW  = 8 * CrcBytes;

  localparam logic [7:0]     CrcPoly         = 8'h07;
  localparam logic [LenW-1:0] FrameDlc       = 4'd8;
  localparam logic [7:0]     ProtocolVersion = 8'd1;
  localparam logic [7:0]     ExpAllOnes      = 8'hFF;

  localparam logic [7:0] EnableMaskReset = 8'h01;
  localparam logic [7:0] EstopMaskReset  = 8'h02;

  typedef enum logic [1:0] {
    KIND_UNKNOWN   = 2'd0,
    KIND_MOTION    = 2'd1,
    KIND_PARAMETER = 2'd2,
    KIND_SYSTEM    = 2'd3
  } frame_kind_t;

  typedef enum logic [2:0] {
    REG_MOTION_ID    = 3'd0,
    REG_PARAMETER_ID = 3'd1,
    REG_SYSTEM_ID    = 3'd2,
    REG_KEY_FIRST    = 3'd3,
    REG_KEY_SECOND   = 3'd4,
    REG_ENABLE_MASK  = 3'd5,
    REG_ESTOP_MASK   = 3'd6,
    REG_UNUSED       = 3'd7
  } reg_index_t;

  // Contribution of message bit pos (weight x^pos) to the CRC: x^(pos+8) mod P.
  function automatic logic [7:0] crc_column(input int unsigned pos);
    logic [7:0] r;
    r = 8'h01;
    for (int unsigned k = 0; k < pos + 8; k++) begin
      r = {r[6:0], 1'b0} ^ (r[7] ? CrcPoly : 8'h00);
    end
    return r;
  endfunction

  // CRC-8/ATM with zero init over a message whose first bit is msg[CrcMsgW-1].
  // The CRC is linear, so it is the XOR of the columns of the set bits.
  function automatic logic [7:0] crc8_msg(input logic [CrcMsgW-1:0] msg);
    logic [7:0] acc;
    acc = 8'h00;
    for (int unsigned p = 0; p < CrcMsgW; p++) begin
      acc = acc ^ (msg[p] ? crc_column(p) : 8'h00);
    end
    return acc;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/command_frame_validator_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// command_frame_validator_decoder
// Classifies and checks one received CAN command frame and decodes its fields.
// ----------------------------------------------------------------------------
// Usage: a frame (identifier, length code, eight data bytes) enters on the
// in_ channel with valid/ready. Each item is registered, then classified by
// identifier (motion, parameter, system in that priority), checked for length
// 8, CRC-8/ATM over bytes 0 to 6 against byte 7 and its kind check, and the
// decoded result item is registered on the out_ channel.
// An accepted item passes the input stage, then the result stage, where
// out_valid rises. Throughput is one item per cycle while the receiver does
// not stall, set by the single input stage and single result stage; the CRC
// is a flat XOR network of the 56 message bits.
// Reset (rst_n low, synchronous) empties both stages and restores the
// register defaults. When the receiver stalls, the result stays held and the
// input stage still takes one more item; after that in_ready drops until the
// result is taken. in_ready follows out_ready in the same cycle.
// Configuration is an APB-style port with registers at byte address 4*index;
// it should be written only while no item is in flight. pready is tied high.
// ----------------------------------------------------------------------------
module command_frame_validator_decoder (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input channel
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [cfvd_pkg::IdW-1:0]      in_frame_id,
  input  wire logic [cfvd_pkg::LenW-1:0]     in_frame_length,
  input  wire logic [7:0]                    in_data_byte_0,
  input  wire logic [7:0]                    in_data_byte_1,
  input  wire logic [7:0]                    in_data_byte_2,
  input  wire logic [7:0]                    in_data_byte_3,
  input  wire logic [7:0]                    in_data_byte_4,
  input  wire logic [7:0]                    in_data_byte_5,
  input  wire logic [7:0]                    in_data_byte_6,
  input  wire logic [7:0]                    in_data_byte_7,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_accepted,
  output logic [1:0]                         out_frame_kind,
  output logic signed [15:0]                 out_linear_mm_s,
  output logic signed [15:0]                 out_angular_mrad_s,
  output logic [1:0]                         out_command_flags,
  output logic [7:0]                         out_sequence_number,
  output logic [7:0]                         out_parameter_number,
  output logic [7:0]                         out_parameter_operation,
  output logic [31:0]                        out_value_bits,
  output logic [7:0]                         out_system_opcode,
  output logic [23:0]                        out_system_arguments,
  // configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [cfvd_pkg::AddrW-1:0]    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  localparam int unsigned IdW = cfvd_pkg::IdW;

  // Configuration registers.
  logic [IdW-1:0] motion_id_r, parameter_id_r, system_id_r;
  logic [7:0]     key_first_r, key_second_r, enable_mask_r, estop_mask_r;

  cfvd_pkg::reg_index_t reg_idx;
  logic                 cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = cfvd_pkg::reg_index_t'(paddr[cfvd_pkg::AddrW-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      motion_id_r    <= '0;
      parameter_id_r <= '0;
      system_id_r    <= '0;
      key_first_r    <= '0;
      key_second_r   <= '0;
      enable_mask_r  <= cfvd_pkg::EnableMaskReset;
      estop_mask_r   <= cfvd_pkg::EstopMaskReset;
    end else if (cfg_wr) begin
      case (reg_idx)
        cfvd_pkg::REG_MOTION_ID:    motion_id_r    <= pwdata[IdW-1:0];
        cfvd_pkg::REG_PARAMETER_ID: parameter_id_r <= pwdata[IdW-1:0];
        cfvd_pkg::REG_SYSTEM_ID:    system_id_r    <= pwdata[IdW-1:0];
        cfvd_pkg::REG_KEY_FIRST:    key_first_r    <= pwdata[7:0];
        cfvd_pkg::REG_KEY_SECOND:   key_second_r   <= pwdata[7:0];
        cfvd_pkg::REG_ENABLE_MASK:  enable_mask_r  <= pwdata[7:0];
        cfvd_pkg::REG_ESTOP_MASK:   estop_mask_r   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      cfvd_pkg::REG_MOTION_ID:    prdata = {{(32-IdW){1'b0}}, motion_id_r};
      cfvd_pkg::REG_PARAMETER_ID: prdata = {{(32-IdW){1'b0}}, parameter_id_r};
      cfvd_pkg::REG_SYSTEM_ID:    prdata = {{(32-IdW){1'b0}}, system_id_r};
      cfvd_pkg::REG_KEY_FIRST:    prdata = {24'h0, key_first_r};
      cfvd_pkg::REG_KEY_SECOND:   prdata = {24'h0, key_second_r};
      cfvd_pkg::REG_ENABLE_MASK:  prdata = {24'h0, enable_mask_r};
      cfvd_pkg::REG_ESTOP_MASK:   prdata = {24'h0, estop_mask_r};
      default:                    prdata = 32'h0;
    endcase
  end

  // Pipeline control: the result stage advances when empty or being taken.
  logic s1_valid_r, out_valid_r;
  logic s2_en, s1_en;

  assign s2_en    = !out_valid_r || out_ready;
  assign s1_en    = !s1_valid_r || s2_en;
  assign in_ready = s1_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_valid_r <= in_valid;
      end
      if (s2_en) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // Input stage.
  logic [IdW-1:0]            id_r;
  logic [cfvd_pkg::LenW-1:0] len_r;
  logic [7:0]                d0_r, d1_r, d2_r, d3_r, d4_r, d5_r, d6_r, d7_r;

  always_ff @(posedge clk) begin
    if (s1_en && in_valid) begin
      id_r  <= in_frame_id;
      len_r <= in_frame_length;
      d0_r  <= in_data_byte_0;
      d1_r  <= in_data_byte_1;
      d2_r  <= in_data_byte_2;
      d3_r  <= in_data_byte_3;
      d4_r  <= in_data_byte_4;
      d5_r  <= in_data_byte_5;
      d6_r  <= in_data_byte_6;
      d7_r  <= in_data_byte_7;
    end
  end

  // Decode.
  logic                  base_ok;
  logic [31:0]           param_bits;
  cfvd_pkg::frame_kind_t kind_nxt;
  logic                  accepted_nxt;
  logic [15:0]           linear_nxt, angular_nxt;
  logic [1:0]            flags_nxt;
  logic [7:0]            seq_nxt, pnum_nxt, pop_nxt, sysop_nxt;
  logic [31:0]           value_nxt;
  logic [23:0]           sysargs_nxt;

  assign base_ok = (len_r == cfvd_pkg::FrameDlc) &&
                   (cfvd_pkg::crc8_msg({d0_r, d1_r, d2_r, d3_r, d4_r, d5_r, d6_r}) == d7_r);
  assign param_bits = {d5_r, d4_r, d3_r, d2_r};

  always_comb begin
    kind_nxt     = cfvd_pkg::KIND_UNKNOWN;
    accepted_nxt = 1'b0;
    linear_nxt   = '0;
    angular_nxt  = '0;
    flags_nxt    = '0;
    seq_nxt      = '0;
    pnum_nxt     = '0;
    pop_nxt      = '0;
    value_nxt    = '0;
    sysop_nxt    = '0;
    sysargs_nxt  = '0;
    if (id_r == motion_id_r) begin
      kind_nxt     = cfvd_pkg::KIND_MOTION;
      accepted_nxt = base_ok && (d5_r == cfvd_pkg::ProtocolVersion);
      linear_nxt   = {d1_r, d0_r};
      angular_nxt  = {d3_r, d2_r};
      flags_nxt    = {|(d4_r & estop_mask_r), |(d4_r & enable_mask_r)};
      seq_nxt      = d6_r;
    end else if (id_r == parameter_id_r) begin
      // A value whose exponent is all ones is an infinity or a NaN.
      kind_nxt     = cfvd_pkg::KIND_PARAMETER;
      accepted_nxt = base_ok && (param_bits[30:23] != cfvd_pkg::ExpAllOnes);
      seq_nxt      = d6_r;
      pnum_nxt     = d0_r;
      pop_nxt      = d1_r;
      value_nxt    = param_bits;
    end else if (id_r == system_id_r) begin
      kind_nxt     = cfvd_pkg::KIND_SYSTEM;
      accepted_nxt = base_ok && (d1_r == key_first_r) && (d2_r == key_second_r);
      seq_nxt      = d3_r;
      sysop_nxt    = d0_r;
      sysargs_nxt  = {d6_r, d5_r, d4_r};
    end
  end

  // Result stage.
  logic                  accepted_r;
  cfvd_pkg::frame_kind_t kind_r;
  logic [15:0]           linear_r, angular_r;
  logic [1:0]            flags_r;
  logic [7:0]            seq_r, pnum_r, pop_r, sysop_r;
  logic [31:0]           value_r;
  logic [23:0]           sysargs_r;

  always_ff @(posedge clk) begin
    if (s2_en && s1_valid_r) begin
      accepted_r <= accepted_nxt;
      kind_r     <= kind_nxt;
      linear_r   <= linear_nxt;
      angular_r  <= angular_nxt;
      flags_r    <= flags_nxt;
      seq_r      <= seq_nxt;
      pnum_r     <= pnum_nxt;
      pop_r      <= pop_nxt;
      value_r    <= value_nxt;
      sysop_r    <= sysop_nxt;
      sysargs_r  <= sysargs_nxt;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_accepted            = accepted_r;
  assign out_frame_kind          = kind_r;
  assign out_linear_mm_s         = signed'(linear_r);
  assign out_angular_mrad_s      = signed'(angular_r);
  assign out_command_flags       = flags_r;
  assign out_sequence_number     = seq_r;
  assign out_parameter_number    = pnum_r;
  assign out_parameter_operation = pop_r;
  assign out_value_bits          = value_r;
  assign out_system_opcode       = sysop_r;
  assign out_system_arguments    = sysargs_r;

`ifndef SYNTH
  // An item in the input stage always reaches the result stage when it opens.
  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s2_en |=> out_valid_r)
    else $error("registered item did not reach the result stage");

  // A receiver that is ready never blocks the input side.
  a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("in_ready low while out_ready high");

  a_unknown_not_accepted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (kind_r == cfvd_pkg::KIND_UNKNOWN) |-> !accepted_r)
    else $error("unknown identifier reported as accepted");

  a_unknown_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (kind_r == cfvd_pkg::KIND_UNKNOWN) |->
      (linear_r == '0) && (angular_r == '0) && (flags_r == '0) && (seq_r == '0) &&
      (pnum_r == '0) && (pop_r == '0) && (value_r == '0) && (sysop_r == '0) &&
      (sysargs_r == '0))
    else $error("unknown identifier carries decoded fields");

  a_motion_fields_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (kind_r == cfvd_pkg::KIND_MOTION) |->
      (value_r == '0) && (sysargs_r == '0) && (pnum_r == '0))
    else $error("motion item carries fields of another kind");
`endif

endmodule
`default_nettype wire

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the command frame validator and decoder: a directed
// table of frames, then randomized frame traffic under several register
// settings; each result is checked against a local decoder or a typed row.
// ----------------------------------------------------------------------------
module tb_top;
  import cfvd_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned PHASES         = 8;
  localparam int unsigned PHASE_ITEMS    = 235;

  typedef struct packed {
    logic [IdW-1:0]  id;
    logic [LenW-1:0] len;
    logic [63:0]     bytes;   // data byte i sits at bits 8*i+7 .. 8*i
  } frame_t;

  typedef struct packed {
    logic [IdW-1:0] motion_id;
    logic [IdW-1:0] param_id;
    logic [IdW-1:0] sys_id;
    logic [7:0]     key_first;
    logic [7:0]     key_second;
    logic [7:0]     en_mask;
    logic [7:0]     es_mask;
  } cfg_t;

  typedef struct packed {
    logic               accepted;
    frame_kind_t        kind;
    logic signed [15:0] linear;
    logic signed [15:0] angular;
    logic [1:0]         flags;
    logic [7:0]         seq;
    logic [7:0]         param_num;
    logic [7:0]         param_op;
    logic [31:0]        value;
    logic [7:0]         opcode;
    logic [23:0]        args;
  } result_t;

  typedef struct {
    int unsigned set_idx;
    frame_t      f;
    bit          fix_crc;
    bit          typed;        // typed rows expect a rejected, all-zero item of typed_kind
    frame_kind_t typed_kind;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic            in_valid = 1'b0;
  logic            in_ready;
  logic [IdW-1:0]  in_frame_id = '0;
  logic [LenW-1:0] in_frame_length = '0;
  logic [7:0]      in_data_byte_0 = '0;
  logic [7:0]      in_data_byte_1 = '0;
  logic [7:0]      in_data_byte_2 = '0;
  logic [7:0]      in_data_byte_3 = '0;
  logic [7:0]      in_data_byte_4 = '0;
  logic [7:0]      in_data_byte_5 = '0;
  logic [7:0]      in_data_byte_6 = '0;
  logic [7:0]      in_data_byte_7 = '0;

  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_accepted;
  logic [1:0]         out_frame_kind;
  logic signed [15:0] out_linear_mm_s;
  logic signed [15:0] out_angular_mrad_s;
  logic [1:0]         out_command_flags;
  logic [7:0]         out_sequence_number;
  logic [7:0]         out_parameter_number;
  logic [7:0]         out_parameter_operation;
  logic [31:0]        out_value_bits;
  logic [7:0]         out_system_opcode;
  logic [23:0]        out_system_arguments;

  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [31:0]      pwdata = '0;
  logic [31:0]      prdata;
  logic             pready;

  result_t     awaited_decodes[$];
  dir_row_t    dir_tab[$];
  cfg_t        dir_cfg[4];
  cfg_t        cur_cfg;
  reg_index_t  reg_list[7] = '{REG_MOTION_ID, REG_PARAMETER_ID, REG_SYSTEM_ID,
                               REG_KEY_FIRST, REG_KEY_SECOND, REG_ENABLE_MASK,
                               REG_ESTOP_MASK};
  bit          calm = 1'b0;
  int unsigned fail_count = 0;
  int unsigned idle_cycles = 0;

  command_frame_validator_decoder u_top (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .in_frame_id             (in_frame_id),
    .in_frame_length         (in_frame_length),
    .in_data_byte_0          (in_data_byte_0),
    .in_data_byte_1          (in_data_byte_1),
    .in_data_byte_2          (in_data_byte_2),
    .in_data_byte_3          (in_data_byte_3),
    .in_data_byte_4          (in_data_byte_4),
    .in_data_byte_5          (in_data_byte_5),
    .in_data_byte_6          (in_data_byte_6),
    .in_data_byte_7          (in_data_byte_7),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_accepted            (out_accepted),
    .out_frame_kind          (out_frame_kind),
    .out_linear_mm_s         (out_linear_mm_s),
    .out_angular_mrad_s      (out_angular_mrad_s),
    .out_command_flags       (out_command_flags),
    .out_sequence_number     (out_sequence_number),
    .out_parameter_number    (out_parameter_number),
    .out_parameter_operation (out_parameter_operation),
    .out_value_bits          (out_value_bits),
    .out_system_opcode       (out_system_opcode),
    .out_system_arguments    (out_system_arguments),
    .psel                    (psel),
    .penable                 (penable),
    .pwrite                  (pwrite),
    .paddr                   (paddr),
    .pwdata                  (pwdata),
    .prdata                  (prdata),
    .pready                  (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Bitwise CRC-8/ATM over data bytes 0 to 6, zero init, no reflection.
  function automatic logic [7:0] atm_crc7(input logic [63:0] bytes);
    logic [7:0] crc;
    crc = 8'h00;
    for (int i = 0; i < 7; i++) begin
      crc = crc ^ bytes[8*i +: 8];
      for (int b = 0; b < 8; b++) begin
        crc = crc[7] ? ({crc[6:0], 1'b0} ^ CrcPoly) : {crc[6:0], 1'b0};
      end
    end
    return crc;
  endfunction

  function automatic result_t decode_frame(input frame_t f, input cfg_t c);
    result_t    r;
    logic [7:0] d [8];
    logic       base_ok;
    logic [31:0] bits;
    r = '0;
    for (int i = 0; i < 8; i++) d[i] = f.bytes[8*i +: 8];
    base_ok = (f.len == FrameDlc) && (atm_crc7(f.bytes) == d[7]);
    bits = {d[5], d[4], d[3], d[2]};
    if (f.id == c.motion_id) begin
      r.kind     = KIND_MOTION;
      r.accepted = base_ok && (d[5] == ProtocolVersion);
      r.linear   = {d[1], d[0]};
      r.angular  = {d[3], d[2]};
      r.flags    = {|(d[4] & c.es_mask), |(d[4] & c.en_mask)};
      r.seq      = d[6];
    end else if (f.id == c.param_id) begin
      r.kind      = KIND_PARAMETER;
      r.accepted  = base_ok && (bits[30:23] != ExpAllOnes);
      r.seq       = d[6];
      r.param_num = d[0];
      r.param_op  = d[1];
      r.value     = bits;
    end else if (f.id == c.sys_id) begin
      r.kind     = KIND_SYSTEM;
      r.accepted = base_ok && (d[1] == c.key_first) && (d[2] == c.key_second);
      r.seq      = d[3];
      r.opcode   = d[0];
      r.args     = {d[6], d[5], d[4]};
    end
    return r;
  endfunction

  function automatic logic [31:0] reg_value(input cfg_t c, input reg_index_t idx);
    case (idx)
      REG_MOTION_ID:    return 32'(c.motion_id);
      REG_PARAMETER_ID: return 32'(c.param_id);
      REG_SYSTEM_ID:    return 32'(c.sys_id);
      REG_KEY_FIRST:    return 32'(c.key_first);
      REG_KEY_SECOND:   return 32'(c.key_second);
      REG_ENABLE_MASK:  return 32'(c.en_mask);
      REG_ESTOP_MASK:   return 32'(c.es_mask);
      default:          return 32'h0;
    endcase
  endfunction

  function automatic string fmt_result(input result_t r);
    return $sformatf({"acc=%0d kind=%0d lin=%0d ang=%0d flg=%0d seq=%02h pn=%02h",
                      " op=%02h val=%08h opc=%02h arg=%06h"},
                     r.accepted, r.kind, r.linear, r.angular, r.flags, r.seq,
                     r.param_num, r.param_op, r.value, r.opcode, r.args);
  endfunction

  function automatic cfg_t random_cfg(input int unsigned round);
    cfg_t       c;
    logic [IdW-1:0] ids [3];
    if (round == 0) return '1;
    if (round == 1) return '0;
    for (int i = 0; i < 3; i++) begin
      case ($urandom_range(0, 3))
        0:       ids[i] = '0;
        1:       ids[i] = '1;
        2:       ids[i] = (i == 0) ? IdW'($urandom) : ids[i-1];
        default: ids[i] = IdW'($urandom);
      endcase
    end
    c.motion_id  = ids[0];
    c.param_id   = ids[1];
    c.sys_id     = ids[2];
    c.key_first  = 8'($urandom);
    c.key_second = 8'($urandom);
    c.en_mask    = ($urandom_range(0, 6) == 0) ? 8'h00 : 8'($urandom);
    c.es_mask    = ($urandom_range(0, 6) == 0) ? 8'h00 : 8'($urandom);
    return c;
  endfunction

  // Mostly well-formed frames aimed at the configured identifiers, so that the
  // kind checks are reached; a small share is pure noise.
  function automatic frame_t make_frame();
    frame_t      f;
    int unsigned pick;
    pick    = $urandom_range(0, 99);
    f.id    = IdW'($urandom);
    f.len   = FrameDlc;
    f.bytes = {$urandom, $urandom};
    if (pick >= 94) begin
      f.len = LenW'($urandom_range(0, 15));
      return f;
    end
    if (pick < 28) begin
      f.id = cur_cfg.motion_id;
      if ($urandom_range(0, 9) != 0) f.bytes[47:40] = ProtocolVersion;
    end else if (pick < 52) begin
      f.id = cur_cfg.param_id;
      if ($urandom_range(0, 9) == 0) f.bytes[46:39] = ExpAllOnes;
    end else if (pick < 76) begin
      f.id = cur_cfg.sys_id;
      if ($urandom_range(0, 9) != 0) f.bytes[15:8] = cur_cfg.key_first;
      if ($urandom_range(0, 9) != 0) f.bytes[23:16] = cur_cfg.key_second;
    end
    if ($urandom_range(0, 11) == 0) f.len = LenW'($urandom_range(0, 15));
    if ($urandom_range(0, 9) != 0) f.bytes[63:56] = atm_crc7(f.bytes);
    return f;
  endfunction

  task automatic flag_error(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("ERROR: %s", msg);
  endtask

  task automatic add_row(input int unsigned set_idx, input logic [IdW-1:0] id,
                         input logic [LenW-1:0] len, input logic [63:0] bytes,
                         input bit fix_crc, input bit typed, input frame_kind_t kind);
    dir_row_t row;
    row.set_idx    = set_idx;
    row.f.id       = id;
    row.f.len      = len;
    row.f.bytes    = bytes;
    row.fix_crc    = fix_crc;
    row.typed      = typed;
    row.typed_kind = kind;
    dir_tab.push_back(row);
  endtask

  // Called at a clock edge; leaves psel high so transfers can run back to back.
  task automatic apb_access(input bit wr, input reg_index_t idx, input logic [31:0] data,
                            output logic [31:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
  endtask

  task automatic apply_cfg(input cfg_t c);
    logic [31:0] rd;
    in_valid <= 1'b0;
    while (awaited_decodes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    foreach (reg_list[i]) apb_access(1'b1, reg_list[i], reg_value(c, reg_list[i]), rd);
    // A write past the register list must leave every register alone.
    apb_access(1'b1, REG_UNUSED, $urandom, rd);
    foreach (reg_list[i]) begin
      apb_access(1'b0, reg_list[i], 32'h0, rd);
      if (rd !== reg_value(c, reg_list[i]))
        flag_error($sformatf("register %s read %08h, wrote %08h", reg_list[i].name(),
                             rd, reg_value(c, reg_list[i])));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    cur_cfg = c;
  endtask

  task automatic send_frame(input frame_t f, input result_t want);
    while (!calm && ($urandom_range(0, 99) < 16)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_frame_id     <= f.id;
    in_frame_length <= f.len;
    in_data_byte_0  <= f.bytes[7:0];
    in_data_byte_1  <= f.bytes[15:8];
    in_data_byte_2  <= f.bytes[23:16];
    in_data_byte_3  <= f.bytes[31:24];
    in_data_byte_4  <= f.bytes[39:32];
    in_data_byte_5  <= f.bytes[47:40];
    in_data_byte_6  <= f.bytes[55:48];
    in_data_byte_7  <= f.bytes[63:56];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    awaited_decodes.push_back(want);
  endtask

  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      got.accepted  = out_accepted;
      got.kind      = frame_kind_t'(out_frame_kind);
      got.linear    = out_linear_mm_s;
      got.angular   = out_angular_mrad_s;
      got.flags     = out_command_flags;
      got.seq       = out_sequence_number;
      got.param_num = out_parameter_number;
      got.param_op  = out_parameter_operation;
      got.value     = out_value_bits;
      got.opcode    = out_system_opcode;
      got.args      = out_system_arguments;
      if (awaited_decodes.size() == 0) begin
        flag_error($sformatf("unexpected item: %s", fmt_result(got)));
      end else begin
        want = awaited_decodes.pop_front();
        if (got !== want)
          flag_error($sformatf("mismatch\n  exp %s\n  act %s", fmt_result(want),
                               fmt_result(got)));
      end
    end
    out_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 16);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    frame_t  f;
    result_t want;
    int unsigned cur_set;

    cur_cfg    = {29'd0, 29'd0, 29'd0, 8'd0, 8'd0, EnableMaskReset, EstopMaskReset};
    dir_cfg[0] = cur_cfg;
    dir_cfg[1] = {29'h123, 29'h0ABCDEF, 29'h1FFFFFFF, 8'hA5, 8'h5A, 8'h01, 8'h80};
    dir_cfg[2] = {29'h777, 29'h777, 29'h777, 8'h00, 8'h00, 8'h00, 8'h00};
    dir_cfg[3] = {29'h001, 29'h777, 29'h777, 8'hFF, 8'h00, 8'hFF, 8'hFF};

    // Register defaults: every identifier is 0, so id 0 decodes as motion.
    add_row(0, 29'h0,        4'd8,  64'h0,                   0, 1, KIND_MOTION);
    add_row(0, 29'h1FFFFFFF, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 0, 1, KIND_UNKNOWN);
    add_row(0, 29'h1,        4'd0,  64'h0,                   0, 1, KIND_UNKNOWN);
    add_row(0, 29'h0,        4'd8,  64'h00_5C_01_03_7F_FF_80_00, 1, 0, KIND_UNKNOWN);
    // Distinct identifiers: good and broken frames of every kind.
    add_row(1, 29'h123,      4'd8,  64'h00_FF_01_81_80_00_7F_FF, 1, 0, KIND_UNKNOWN);
    add_row(1, 29'h123,      4'd8,  64'h3C_FF_01_81_80_00_7F_FF, 0, 0, KIND_UNKNOWN);
    add_row(1, 29'h123,      4'd7,  64'h00_01_01_01_34_12_78_56, 1, 0, KIND_UNKNOWN);
    add_row(1, 29'h123,      4'd8,  64'h00_10_02_02_00_00_00_64, 1, 0, KIND_UNKNOWN);
    add_row(1, 29'h0ABCDEF,  4'd8,  64'h00_11_7F_7F_FF_FF_03_2A, 1, 0, KIND_UNKNOWN);
    add_row(1, 29'h0ABCDEF,  4'd8,  64'h00_12_7F_80_00_00_01_07, 1, 0, KIND_UNKNOWN);
    add_row(1, 29'h0ABCDEF,  4'd8,  64'h00_13_FF_FF_FF_FF_02_FF, 1, 0, KIND_UNKNOWN);
    add_row(1, 29'h0ABCDEF,  4'd8,  64'h00_14_80_00_00_00_00_00, 1, 0, KIND_UNKNOWN);
    add_row(1, 29'h1FFFFFFF, 4'd8,  64'h00_FF_FF_FF_77_5A_A5_FF, 1, 0, KIND_UNKNOWN);
    add_row(1, 29'h1FFFFFFF, 4'd8,  64'h00_03_02_01_09_5A_A4_10, 1, 0, KIND_UNKNOWN);
    add_row(1, 29'h1FFFFFFF, 4'd8,  64'h00_03_02_01_09_5B_A5_10, 1, 0, KIND_UNKNOWN);
    add_row(1, 29'h1FFFFFFF, 4'd8,  64'hEE_03_02_01_09_5A_A5_10, 0, 0, KIND_UNKNOWN);
    add_row(1, 29'h1FFFFFFF, 4'd9,  64'h00_03_02_01_09_5A_A5_10, 1, 0, KIND_UNKNOWN);
    add_row(1, 29'h0,        4'd8,  64'h00_21_01_00_00_00_00_00, 1, 1, KIND_UNKNOWN);
    // Equal identifiers with zero flag masks, then parameter over system.
    add_row(2, 29'h777,      4'd8,  64'h00_01_01_FF_00_00_00_00, 1, 0, KIND_UNKNOWN);
    add_row(3, 29'h777,      4'd8,  64'h00_05_3F_80_00_00_01_02, 1, 0, KIND_UNKNOWN);
    add_row(3, 29'h001,      4'd8,  64'h00_06_01_01_00_10_FF_F0, 1, 0, KIND_UNKNOWN);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    cur_set = 0;
    foreach (dir_tab[k]) begin
      if (dir_tab[k].set_idx != cur_set) begin
        apply_cfg(dir_cfg[dir_tab[k].set_idx]);
        cur_set = dir_tab[k].set_idx;
      end
      f = dir_tab[k].f;
      if (dir_tab[k].fix_crc) f.bytes[63:56] = atm_crc7(f.bytes);
      if (dir_tab[k].typed) begin
        want      = '0;
        want.kind = dir_tab[k].typed_kind;
      end else begin
        want = decode_frame(f, cur_cfg);
      end
      send_frame(f, want);
    end

    for (int unsigned round = 0; round < PHASES; round++) begin
      apply_cfg(random_cfg(round));
      calm = (round == 3);
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        f = make_frame();
        send_frame(f, decode_frame(f, cur_cfg));
      end
    end
    calm = 1'b0;

    in_valid <= 1'b0;
    while (awaited_decodes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
